### design/alr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_pkg
// Shared types and defaults for the antialiased line rasterizer.
// ----------------------------------------------------------------------------
package alr_pkg;

  localparam int COORD_BITS_DEF = 6;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WALK
  } state_t;

  typedef enum logic [2:0] {
    CLS_VERT    = 3'd0,
    CLS_STEEP_U = 3'd1,
    CLS_FLAT_U  = 3'd2,
    CLS_FLAT_D  = 3'd3,
    CLS_STEEP_D = 3'd4
  } slope_t;

  typedef struct packed {
    logic load;
    logic inc_load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic go;
    logic vert;
    logic div_done;
    logic last;
  } status_t;

endpackage

### design/antialiased_line_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer
// Wu-style antialiased line drawer with a pen position.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser is the mode (0 move the pen, 1 draw a line from
//   the pen), in_tdata carries the target point. Each request moves the pen.
//   Output stream: one pixel pair per beat, out_tlast on the final pair of a
//   line. A move, or a line of zero length, yields no beats.
//   Timing: a request is taken only while the block is idle. A vertical line
//   starts emitting in the cycle after acceptance; any other line first runs a
//   restoring slope divider, then emits one pair per cycle while out_tready is
//   high, up to 2^COORD_BITS-1 pairs. The block is ready again the cycle after
//   the last beat is taken.
//   Stall: while out_tready is low the current pair is held unchanged and the
//   walk waits.
//   Reset: synchronous, active low; pen returns to the origin and any line
//   in flight is dropped.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer #(
  parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF,
  localparam int IN_W  = ((2 * COORD_BITS) + 7) / 8 * 8,
  localparam int OUT_W = ((4 * COORD_BITS) + 19 + 7) / 8 * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // target_x, target_y
  input  logic [IN_W-1:0]  in_tdata,
  // mode
  input  logic             in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // base_x, base_y, base_grey, side_x, side_y, side_grey
  output logic [OUT_W-1:0] out_tdata,
  // side_valid, solid_red
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);
  alr_pkg::cmd_t    cmd;
  alr_pkg::status_t sts;
  alr_pkg::state_t  state;

  logic [COORD_BITS-1:0]        base_x, base_y;
  logic [7:0]                   base_grey, side_grey;
  logic [COORD_BITS:0]          side_x;
  logic signed [COORD_BITS+1:0] side_y;
  logic                         side_valid, solid_red;

  // Sequencer: owns the handshakes, drives the datapath by command
  alr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tlast (out_tlast),
    .sts       (sts),
    .cmd       (cmd),
    .state     (state)
  );

  // Datapath: pen, slope divider, walk and grey computation
  alr_dp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .mode      (in_tuser),
    .target_x  (in_tdata[COORD_BITS-1:0]),
    .target_y  (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .base_x    (base_x),
    .base_y    (base_y),
    .base_grey (base_grey),
    .side_x    (side_x),
    .side_y    (side_y),
    .side_grey (side_grey),
    .side_valid(side_valid),
    .solid_red (solid_red)
  );

  // Pack the pair, lowest field first; pad to whole bytes
  assign out_tdata = OUT_W'({side_grey, side_y, side_x, base_grey, base_y, base_x});
  assign out_tuser = {solid_red, side_valid};

  // Request intake and result emission never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("request taken while a pair is pending");

  // A pair is either a red vertical pixel or an antialiased pair
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (side_valid != solid_red))
    else $error("pixel kind flags inconsistent");

  // After the final pair is taken the block is idle again
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (state == alr_pkg::ST_IDLE))
    else $error("walk did not finish on last pair");

  // Walk only starts from a divide or directly from an accepted request
  a_walk_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(cmd.inc_load) || $past(cmd.load)))
    else $error("walk entered without set-up");
endmodule

### design/alr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_div
// Restoring divider, one quotient bit a cycle: (num << FRAC_BITS) / den.
// ----------------------------------------------------------------------------
module alr_div #(
  parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] num,
  input  logic [COORD_BITS-1:0] den,
  output logic                  done,
  output logic [FRAC_BITS:0]    quot
);
  localparam int N  = COORD_BITS + FRAC_BITS;
  localparam int CW = $clog2(N);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [N-1:0]          dvd_r, dvd_nxt;
  logic [COORD_BITS-1:0] rem_r, rem_nxt;
  logic [COORD_BITS-1:0] den_r, den_nxt;
  logic [FRAC_BITS:0]    q_r, q_nxt;
  logic [COORD_BITS:0]   trial;
  logic                  ge;

  always_comb begin
    trial    = {rem_r, dvd_r[N-1]};
    ge       = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = {num, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      den_nxt  = den;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? COORD_BITS'(trial - {1'b0, den_r}) : trial[COORD_BITS-1:0];
      q_nxt   = {q_r[FRAC_BITS-1:0], ge};
      dvd_nxt = {dvd_r[N-2:0], 1'b0};
      cnt_nxt = CW'(cnt_r + 1'b1);
      if (cnt_r == CW'(N - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

### design/alr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_dp
// Pen, walk registers, error accumulator and pixel-pair formatting.
// ----------------------------------------------------------------------------
module alr_dp #(
  parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  alr_pkg::cmd_t                cmd,
  output alr_pkg::status_t             sts,
  input  logic                         mode,
  input  logic [COORD_BITS-1:0]        target_x,
  input  logic [COORD_BITS-1:0]        target_y,
  output logic [COORD_BITS-1:0]        base_x,
  output logic [COORD_BITS-1:0]        base_y,
  output logic [7:0]                   base_grey,
  output logic [COORD_BITS:0]          side_x,
  output logic signed [COORD_BITS+1:0] side_y,
  output logic [7:0]                   side_grey,
  output logic                         side_valid,
  output logic                         solid_red
);
  localparam int W = COORD_BITS + 2;
  localparam logic [FRAC_BITS+1:0] ONE = (FRAC_BITS+2)'(1) << FRAC_BITS;

  logic [COORD_BITS-1:0] pen_x_r, pen_y_r;
  logic signed [W-1:0]   major_r, minor_r, end_r;
  logic signed [W-1:0]   major_nxt, minor_nxt, end_nxt;
  logic [FRAC_BITS-1:0]  err_r, err_nxt;
  logic [FRAC_BITS:0]    inc_r;
  alr_pkg::slope_t       cls_r, cls_nxt;

  logic signed [W-1:0]   x0, y0, x1, y1, dx, dy, adx, ady;
  logic                  same, steep, swap;
  logic [COORD_BITS-1:0] div_num, div_den;
  logic                  div_done;
  logic [FRAC_BITS:0]    quot;
  logic [FRAC_BITS+1:0]  err_sum;
  logic signed [W-1:0]   dir;
  logic [FRAC_BITS+7:0]  bg_prod;
  logic [FRAC_BITS:0]    one_m;
  logic [FRAC_BITS+8:0]  sg_prod;

  // Line set-up from pen and target
  always_comb begin
    x0    = W'(pen_x_r);
    y0    = W'(pen_y_r);
    x1    = W'(target_x);
    y1    = W'(target_y);
    dx    = x1 - x0;
    dy    = y1 - y0;
    adx   = dx < 0 ? -dx : dx;
    ady   = dy < 0 ? -dy : dy;
    same  = ((dx > 0) == (dy >= 0)) || (dy == 0);
    steep = ady > adx;
    if (dx == 0)   cls_nxt = alr_pkg::CLS_VERT;
    else if (steep) cls_nxt = same ? alr_pkg::CLS_STEEP_U : alr_pkg::CLS_STEEP_D;
    else           cls_nxt = same ? alr_pkg::CLS_FLAT_U : alr_pkg::CLS_FLAT_D;
    swap = ((cls_nxt == alr_pkg::CLS_STEEP_U) && (y0 > y1)) ||
           ((cls_nxt == alr_pkg::CLS_STEEP_D) && (y0 < y1)) ||
           (((cls_nxt == alr_pkg::CLS_FLAT_U) || (cls_nxt == alr_pkg::CLS_FLAT_D)) &&
            (x0 > x1));
    case (cls_nxt)
      alr_pkg::CLS_VERT: begin
        minor_nxt = x0;
        major_nxt = (y0 < y1) ? y0 : y1;
        end_nxt   = (y0 < y1) ? y1 : y0;
      end
      alr_pkg::CLS_STEEP_U, alr_pkg::CLS_STEEP_D: begin
        major_nxt = swap ? y1 : y0;
        end_nxt   = swap ? y0 : y1;
        minor_nxt = swap ? x1 : x0;
      end
      default: begin
        major_nxt = swap ? x1 : x0;
        end_nxt   = swap ? x0 : x1;
        minor_nxt = swap ? y1 : y0;
      end
    endcase
    div_num = steep ? adx[COORD_BITS-1:0] : ady[COORD_BITS-1:0];
    div_den = steep ? ady[COORD_BITS-1:0] : adx[COORD_BITS-1:0];
  end

  alr_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.load & mode & (dx != 0)),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (quot)
  );

  // Stepping
  always_comb begin
    dir     = (cls_r == alr_pkg::CLS_STEEP_D) ? -W'(1) : W'(1);
    err_sum = {2'b0, err_r} + {1'b0, inc_r};
    err_nxt = err_sum[FRAC_BITS-1:0];
    if (err_sum >= ONE) err_nxt = FRAC_BITS'(err_sum - ONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
      cls_r   <= alr_pkg::CLS_VERT;
    end else if (cmd.load) begin
      pen_x_r <= target_x;
      pen_y_r <= target_y;
      if (mode) cls_r <= cls_nxt;
    end
    if (cmd.load) begin
      major_r <= major_nxt;
      minor_r <= minor_nxt;
      end_r   <= end_nxt;
      err_r   <= '0;
      inc_r   <= '0;
    end else if (cmd.inc_load) begin
      inc_r <= quot;
    end else if (cmd.step) begin
      major_r <= major_r + dir;
      err_r   <= err_nxt;
      if (err_sum >= ONE)
        minor_r <= (cls_r == alr_pkg::CLS_FLAT_D) ? minor_r - W'(1) : minor_r + W'(1);
    end
  end

  // Grey levels: error*255 and (1-error)*255; vertical pixels carry no grey
  always_comb begin
    bg_prod   = {err_r, 8'b0} - {8'b0, err_r};
    base_grey = bg_prod[FRAC_BITS+7:FRAC_BITS];
    one_m     = ONE[FRAC_BITS:0] - {1'b0, err_r};
    sg_prod   = {one_m, 8'b0} - {8'b0, one_m};
    side_grey = (cls_r == alr_pkg::CLS_VERT) ? 8'd0 : sg_prod[FRAC_BITS+7:FRAC_BITS];
  end

  always_comb begin
    side_valid = 1'b1;
    solid_red  = 1'b0;
    case (cls_r)
      alr_pkg::CLS_VERT: begin
        base_x     = minor_r[COORD_BITS-1:0];
        base_y     = major_r[COORD_BITS-1:0];
        side_x     = '0;
        side_y     = '0;
        side_valid = 1'b0;
        solid_red  = 1'b1;
      end
      alr_pkg::CLS_STEEP_U, alr_pkg::CLS_STEEP_D: begin
        base_x = minor_r[COORD_BITS-1:0];
        base_y = major_r[COORD_BITS-1:0];
        side_x = COORD_BITS'(minor_r[COORD_BITS-1:0]) + (COORD_BITS+1)'(1);
        side_y = major_r;
      end
      alr_pkg::CLS_FLAT_U: begin
        base_x = major_r[COORD_BITS-1:0];
        base_y = minor_r[COORD_BITS-1:0];
        side_x = {1'b0, major_r[COORD_BITS-1:0]};
        side_y = minor_r + W'(1);
      end
      default: begin
        base_x = major_r[COORD_BITS-1:0];
        base_y = minor_r[COORD_BITS-1:0];
        side_x = {1'b0, major_r[COORD_BITS-1:0]};
        side_y = minor_r - W'(1);
      end
    endcase
  end

  always_comb begin
    sts.go       = mode & ((dx != 0) | (dy != 0));
    sts.vert     = (dx == 0);
    sts.div_done = div_done;
    sts.last     = (major_r + dir) == end_r;
  end
endmodule

### design/alr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_ctrl
// Sequencer: take a request; for a line, wait for the slope division (skipped when vertical), walk it.
// ----------------------------------------------------------------------------
module alr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic             out_tlast,
  input  alr_pkg::status_t sts,
  output alr_pkg::cmd_t    cmd,
  output alr_pkg::state_t  state
);
  alr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= alr_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    out_tlast    = sts.last;
    case (state_r)
      alr_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (sts.go) state_nxt = sts.vert ? alr_pkg::ST_WALK : alr_pkg::ST_DIV;
        end
      end
      alr_pkg::ST_DIV: begin
        if (sts.div_done) begin
          cmd.inc_load = 1'b1;
          state_nxt    = alr_pkg::ST_WALK;
        end
      end
      alr_pkg::ST_WALK: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.step = 1'b1;
          if (sts.last) state_nxt = alr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = alr_pkg::ST_IDLE;
    endcase
  end

  assign state = state_r;
endmodule
